>>> rtl/qrs_pkg.sv
package qrs_pkg;

	localparam int unsigned SQRT_STAGES = 33;
	localparam int unsigned DIV_STAGES = 50;
	localparam int unsigned RAD_W = 66;
	localparam int unsigned ROOT_W = 33;
	localparam int unsigned NUM_W = 50;
	localparam int unsigned DEN_W = 32;

	typedef enum logic [2:0] {
		KIND_INFINITE = 3'd0,
		KIND_NONE = 3'd1,
		KIND_LINEAR = 3'd2,
		KIND_DOUBLE = 3'd3,
		KIND_TWO = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} sq_side_t;

	typedef struct packed {
		kind_t kind;
		logic neg;
	} dv_side_t;

endpackage

>>> rtl/qrs_sqrt.sv
module qrs_sqrt import qrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [RAD_W-1:0] rad,
	input sq_side_t in_side,
	output logic out_valid,
	output logic [ROOT_W-1:0] root,
	output sq_side_t out_side
);

	logic valid_s [0:SQRT_STAGES-1];
	logic [ROOT_W+1:0] rem_s [0:SQRT_STAGES-1];
	logic [ROOT_W-1:0] root_s [0:SQRT_STAGES-1];
	logic [RAD_W-1:0] rad_s [0:SQRT_STAGES-1];
	sq_side_t side_s [0:SQRT_STAGES-1];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		logic v_in;
		logic [ROOT_W+1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0] rad_in;
		sq_side_t side_in;
		logic [ROOT_W+2:0] remx;
		logic [ROOT_W+2:0] trial;
		logic [ROOT_W+2:0] diff;
		logic take;

		if (j == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = '0;
			assign root_in = '0;
			assign rad_in = rad;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in = valid_s[j-1];
			assign rem_in = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign rad_in = rad_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign remx = {rem_in[ROOT_W:0], rad_in[RAD_W-1:RAD_W-2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff = remx - trial;
		assign take = (remx >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else begin
				valid_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= take ? diff[ROOT_W+1:0] : remx[ROOT_W+1:0];
			root_s[j] <= {root_in[ROOT_W-2:0], take};
			rad_s[j] <= {rad_in[RAD_W-3:0], 2'b00};
			side_s[j] <= side_in;
		end
	end

	assign out_valid = valid_s[SQRT_STAGES-1];
	assign root = root_s[SQRT_STAGES-1];
	assign out_side = side_s[SQRT_STAGES-1];

endmodule

>>> rtl/qrs_div.sv
module qrs_div import qrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	input dv_side_t in_side,
	output logic out_valid,
	output logic [NUM_W-1:0] quo,
	output dv_side_t out_side
);

	logic valid_s [0:DIV_STAGES-1];
	logic [DEN_W-1:0] rem_s [0:DIV_STAGES-1];
	logic [NUM_W-1:0] num_s [0:DIV_STAGES-1];
	logic [NUM_W-1:0] quo_s [0:DIV_STAGES-1];
	logic [DEN_W-1:0] den_s [0:DIV_STAGES-1];
	dv_side_t side_s [0:DIV_STAGES-1];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic v_in;
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] num_in;
		logic [NUM_W-1:0] quo_in;
		logic [DEN_W-1:0] den_in;
		dv_side_t side_in;
		logic [DEN_W:0] remx;
		logic [DEN_W:0] diff;
		logic take;

		if (j == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in = valid_s[j-1];
			assign rem_in = rem_s[j-1];
			assign num_in = num_s[j-1];
			assign quo_in = quo_s[j-1];
			assign den_in = den_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign remx = {rem_in, num_in[NUM_W-1]};
		assign diff = remx - {1'b0, den_in};
		assign take = (remx >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else begin
				valid_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= take ? diff[DEN_W-1:0] : remx[DEN_W-1:0];
			num_s[j] <= {num_in[NUM_W-2:0], 1'b0};
			quo_s[j] <= {quo_in[NUM_W-2:0], take};
			den_s[j] <= den_in;
			side_s[j] <= side_in;
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign quo = quo_s[DIV_STAGES-1];
	assign out_side = side_s[DIV_STAGES-1];

endmodule

>>> rtl/quadratic_root_solver_top.sv
// Quadratic equation solver for a*x^2 + b*x + c = 0 with signed Q16.16
// coefficients on coef_quad, coef_lin and coef_const.
// An item is accepted at a rising edge where start is high and busy is low.
// busy is always low: the pipeline takes one item in every cycle.
// Each item gives one result, shown for exactly one cycle with done high:
// solution_kind, root_first, root_second and saturated.
// done rises after the item passes the coefficient, product and radicand
// registers, the square root, the divider input register, the dividers and
// the result register; the throughput is one item per cycle. The 33-step
// square root and 50-step restoring dividers take one step per stage.
// Results leave in the order in which items were accepted.
// The receiver cannot hold results off, so no stall path exists.
// An asynchronous reset on arst_n clears every valid bit; items in flight
// are dropped and no result appears until a new item is accepted.
module quadratic_root_solver_top import qrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] coef_quad,
	input logic signed [31:0] coef_lin,
	input logic signed [31:0] coef_const,
	output logic done,
	output logic [2:0] solution_kind,
	output logic signed [31:0] root_first,
	output logic signed [31:0] root_second,
	output logic saturated
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [31:0] a_s1, b_s1, c_s1;
	logic signed [31:0] a_s2, b_s2, c_s2;
	logic [63:0] bb_s2;
	logic signed [63:0] p_s2;
	logic [RAD_W-1:0] rad_s3;
	sq_side_t side_s3;

	logic signed [66:0] disc;
	kind_t kind_c;

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sq_side_t sq_side;

	logic [NUM_W-1:0] num1_s4, num2_s4;
	logic [DEN_W-1:0] den_s4;
	dv_side_t side1_s4, side2_s4;

	logic signed [NUM_W:0] n1_c, n2_c;
	logic signed [32:0] den_c;
	logic signed [34:0] nb_c;

	logic dv1_valid, dv2_valid;
	logic [NUM_W-1:0] quo1, quo2;
	dv_side_t dv1_side, dv2_side;

	logic [31:0] r1_c, r2_c;
	logic sat1_c, sat2_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= sq_valid;
			done <= dv1_valid;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= coef_quad;
		b_s1 <= coef_lin;
		c_s1 <= coef_const;
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		c_s2 <= c_s1;
		bb_s2 <= 64'(b_s1 * b_s1);
		p_s2 <= 64'(a_s1 * c_s1);
	end

	assign disc = $signed({3'b000, bb_s2}) - ($signed({{3{p_s2[63]}}, p_s2}) <<< 2);

	always_comb begin
		if (a_s2 == 32'sd0) begin
			if (b_s2 == 32'sd0) begin
				kind_c = (c_s2 == 32'sd0) ? KIND_INFINITE : KIND_NONE;
			end else begin
				kind_c = KIND_LINEAR;
			end
		end else if (disc < 67'sd0) begin
			kind_c = KIND_NONE;
		end else if (disc == 67'sd0) begin
			kind_c = KIND_DOUBLE;
		end else begin
			kind_c = KIND_TWO;
		end
	end

	always_ff @(posedge clk) begin
		rad_s3 <= (kind_c == KIND_TWO) ? disc[RAD_W-1:0] : '0;
		side_s3.kind <= kind_c;
		side_s3.a <= a_s2;
		side_s3.b <= b_s2;
		side_s3.c <= c_s2;
	end

	qrs_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s3),
		.rad(rad_s3),
		.in_side(side_s3),
		.out_valid(sq_valid),
		.root(sq_root),
		.out_side(sq_side)
	);

	assign nb_c = -35'(sq_side.b);

	always_comb begin
		case (sq_side.kind)
			KIND_LINEAR: begin
				n1_c = (-(NUM_W+1)'(sq_side.c)) <<< 16;
				n2_c = '0;
				den_c = 33'(sq_side.b);
			end
			KIND_TWO: begin
				n1_c = (NUM_W+1)'(nb_c - $signed({2'b00, sq_root})) <<< 15;
				n2_c = (NUM_W+1)'(nb_c + $signed({2'b00, sq_root})) <<< 15;
				den_c = 33'(sq_side.a);
			end
			default: begin
				n1_c = (NUM_W+1)'(nb_c) <<< 15;
				n2_c = '0;
				den_c = 33'(sq_side.a);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		num1_s4 <= n1_c[NUM_W] ? NUM_W'(-n1_c) : n1_c[NUM_W-1:0];
		num2_s4 <= n2_c[NUM_W] ? NUM_W'(-n2_c) : n2_c[NUM_W-1:0];
		den_s4 <= den_c[32] ? DEN_W'(-den_c) : den_c[DEN_W-1:0];
		side1_s4.kind <= sq_side.kind;
		side1_s4.neg <= n1_c[NUM_W] ^ den_c[32];
		side2_s4.kind <= sq_side.kind;
		side2_s4.neg <= n2_c[NUM_W] ^ den_c[32];
	end

	qrs_div u_div_first (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s4),
		.num(num1_s4),
		.den(den_s4),
		.in_side(side1_s4),
		.out_valid(dv1_valid),
		.quo(quo1),
		.out_side(dv1_side)
	);

	qrs_div u_div_second (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s4),
		.num(num2_s4),
		.den(den_s4),
		.in_side(side2_s4),
		.out_valid(dv2_valid),
		.quo(quo2),
		.out_side(dv2_side)
	);

	always_comb begin
		if (!dv1_side.neg) begin
			sat1_c = |quo1[NUM_W-1:31];
			r1_c = sat1_c ? 32'h7fff_ffff : quo1[31:0];
		end else begin
			sat1_c = (|quo1[NUM_W-1:32]) || (quo1[31] && |quo1[30:0]);
			r1_c = sat1_c ? 32'h8000_0000 : 32'(-quo1[31:0]);
		end
		if (!dv2_side.neg) begin
			sat2_c = |quo2[NUM_W-1:31];
			r2_c = sat2_c ? 32'h7fff_ffff : quo2[31:0];
		end else begin
			sat2_c = (|quo2[NUM_W-1:32]) || (quo2[31] && |quo2[30:0]);
			r2_c = sat2_c ? 32'h8000_0000 : 32'(-quo2[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		solution_kind <= dv1_side.kind;
		case (dv1_side.kind)
			KIND_LINEAR, KIND_DOUBLE: begin
				root_first <= r1_c;
				root_second <= '0;
				saturated <= sat1_c;
			end
			KIND_TWO: begin
				root_first <= r1_c;
				root_second <= r2_c;
				saturated <= sat1_c || sat2_c;
			end
			default: begin
				root_first <= '0;
				root_second <= '0;
				saturated <= 1'b0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		dv1_valid == dv2_valid && (!dv1_valid || dv1_side.kind == dv2_side.kind))
		else $error("divider lanes out of step");
	a_no_root: assert property (@(posedge clk) disable iff (!arst_n)
		done && (solution_kind == KIND_NONE || solution_kind == KIND_INFINITE)
		|-> root_first == '0 && root_second == '0 && !saturated)
		else $error("root given where none exists");
	a_second_only_two: assert property (@(posedge clk) disable iff (!arst_n)
		done && solution_kind != KIND_TWO |-> root_second == '0)
		else $error("second root set for a single-root kind");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s4, DIV_STAGES + 1))
		else $error("result without an item in the dividers");
`endif

endmodule

>>> tb/sv/tb_quadratic_root_solver_top.sv
`timescale 1ns / 100ps

module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	typedef struct {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} coef_t;

	typedef struct {
		kind_t kind;
		logic signed [31:0] r1;
		logic signed [31:0] r2;
		logic sat;
	} roots_t;

	localparam int LATENCY = 88;
	localparam int IDLE_LIMIT = 2000;
	localparam logic signed [31:0] QMAX = 32'sh7fffffff;
	localparam logic signed [31:0] QMIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] coef_quad = '0;
	logic signed [31:0] coef_lin = '0;
	logic signed [31:0] coef_const = '0;
	logic done;
	logic [2:0] solution_kind;
	logic signed [31:0] root_first;
	logic signed [31:0] root_second;
	logic saturated;

	coef_t pending_eqs[$];
	roots_t expected_roots[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stimulus_done = 0;
	int gap_left = 0;
	int burst_left = 0;

	quadratic_root_solver_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.coef_quad(coef_quad),
		.coef_lin(coef_lin),
		.coef_const(coef_const),
		.done(done),
		.solution_kind(solution_kind),
		.root_first(root_first),
		.root_second(root_second),
		.saturated(saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clip_q(logic signed [127:0] v, ref logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return QMAX;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return QMIN;
		end
		return v[31:0];
	endfunction

	function automatic logic [127:0] isqrt(logic [127:0] d);
		logic [127:0] lo, hi, mid;
		lo = 0;
		hi = 128'd1 << 34;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= d)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic roots_t solve_eq(coef_t e);
		roots_t r;
		logic signed [127:0] a, b, c, d, s;
		logic sat;
		a = e.a;
		b = e.b;
		c = e.c;
		sat = 1'b0;
		r.r1 = '0;
		r.r2 = '0;
		if (a == 0) begin
			if (b == 0) begin
				r.kind = (c == 0) ? KIND_INFINITE : KIND_NONE;
			end else begin
				r.kind = KIND_LINEAR;
				r.r1 = clip_q((-c * 65536) / b, sat);
			end
		end else begin
			d = b * b - 4 * a * c;
			if (d < 0) begin
				r.kind = KIND_NONE;
			end else if (d == 0) begin
				r.kind = KIND_DOUBLE;
				r.r1 = clip_q((-b * 32768) / a, sat);
			end else begin
				s = isqrt(d);
				r.kind = KIND_TWO;
				r.r1 = clip_q(((-b - s) * 32768) / a, sat);
				r.r2 = clip_q(((-b + s) * 32768) / a, sat);
			end
		end
		r.sat = sat;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8)) <<< 16;
			2: return -($signed($urandom_range(0, 8)) <<< 16);
			3: return $signed($urandom_range(0, 2000)) - 1000;
			4: return $urandom_range(0, 3) == 0 ? 32'sd0 : {{12{$urandom_range(0, 1) == 1}},
				20'($urandom)};
			default: return $signed({$urandom} >> $urandom_range(0, 31))
				* ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	task automatic add_eq(logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c);
		coef_t e;
		e.a = a;
		e.b = b;
		e.c = c;
		pending_eqs.push_back(e);
	endtask

	initial begin
		logic signed [31:0] k, m;
		add_eq(0, 0, 0);
		add_eq(0, 0, 32'sh10000);
		add_eq(0, 32'sh20000, 32'sh60000);
		add_eq(0, 1, QMAX);
		add_eq(0, QMIN, QMIN);
		add_eq(0, -1, QMIN);
		add_eq(32'sh10000, -32'sh40000, 32'sh40000);
		add_eq(32'sh10000, 0, 32'sh10000);
		add_eq(32'sh10000, -32'sh30000, 32'sh20000);
		add_eq(QMAX, QMAX, QMAX);
		add_eq(QMIN, QMIN, QMIN);
		add_eq(QMIN, QMAX, QMIN);
		add_eq(QMIN, 0, QMAX);
		add_eq(1, QMIN, 0);
		add_eq(-1, QMAX, 1);
		add_eq(1, 0, 0);
		add_eq(QMAX, 0, -1);
		add_eq(32'hffffffff, 32'hffffffff, 32'hffffffff);
		add_eq(1, 3, 2);
		add_eq(32'sh10000, 1, 0);
		for (int i = 0; i < 600; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				k = $signed($urandom_range(0, 40000)) - 20000;
				m = $signed($urandom_range(1, 300));
				add_eq(m, 2 * m * k, m * k * k);
			end else begin
				add_eq(rand_coef(), rand_coef(), rand_coef());
			end
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_roots.push_back(solve_eq(pending_eqs.pop_front()));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_eqs.size() > 0) begin
					coef_quad <= pending_eqs[0].a;
					coef_lin <= pending_eqs[0].b;
					coef_const <= pending_eqs[0].c;
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		roots_t exp_r;
		if (arst_n) begin
			if (done) begin
				idle_cycles <= 0;
				if (expected_roots.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind=%0d r1=%0d r2=%0d sat=%0b",
							solution_kind, root_first, root_second, saturated);
				end else begin
					exp_r = expected_roots.pop_front();
					if (solution_kind !== exp_r.kind || root_first !== exp_r.r1
						|| root_second !== exp_r.r2 || saturated !== exp_r.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind=%0d r1=%0d r2=%0d sat=%0b, ",
								"got kind=%0d r1=%0d r2=%0d sat=%0b"},
								exp_r.kind, exp_r.r1, exp_r.r2, exp_r.sat,
								solution_kind, root_first, root_second, saturated);
					end
				end
			end else if (start && !busy) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		wait (stimulus_done && expected_roots.size() == 0 || idle_cycles >= IDLE_LIMIT);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			repeat (LATENCY + 10) @(posedge clk);
			if (mismatches == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

>>> filelist.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_top.sv
tb/sv/tb_quadratic_root_solver_top.sv
